/* design/pmd_pkg.sv */
package pmd_pkg;

  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = 6;
  localparam int DIST_BITS  = 17;
  localparam int CNT_BITS   = 7;
  localparam int T_BITS     = 17;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MUL_BITS   = 18;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int LEN_BITS   = 35;

  localparam logic [DIST_BITS-1:0] DIST_MAX          = 17'h1FFFF;
  localparam logic [21:0]          START_DIST        = 22'd1599984;
  localparam logic [CNT_BITS-1:0]  VERTEX_COUNT_RST  = 7'd36;
  localparam logic [DIST_BITS-1:0] VALLEY_RADIUS_RST = 17'd720;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_VALLEY_RADIUS = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic [IDX_BITS-1:0]          vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] min_distance;
    logic                 in_valley;
  } out_word_t;

endpackage

/* design/pmd_mul.sv */
module pmd_mul import pmd_pkg::*; (
  input  logic                        clk,
  input  logic signed [MUL_BITS-1:0]  a,
  input  logic signed [MUL_BITS-1:0]  b,
  output logic signed [PROD_BITS-1:0] prod
);

  // registered 18x18 signed product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* design/pmd_div.sv */
module pmd_div import pmd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [LEN_BITS-1:0] dividend,
  input  logic [LEN_BITS-1:0] divisor,
  output logic                done,
  output logic [T_BITS-1:0]   quotient
);

  // restoring divider, one quotient bit per cycle; needs dividend <= divisor
  logic [LEN_BITS:0] rem;
  logic [4:0]        cnt;
  logic              busy;
  logic [LEN_BITS:0] diff;
  logic              ge;

  assign ge   = rem >= {1'b0, divisor};
  assign diff = rem - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= {1'b0, dividend};
        quotient <= '0;
        cnt      <= 5'(T_BITS);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? {diff[LEN_BITS-1:0], 1'b0} : {rem[LEN_BITS-1:0], 1'b0};
        quotient <= {quotient[T_BITS-2:0], ge};
        cnt      <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/polyline_min_distance.sv */
// Polyline minimum distance. Vertices are loaded one word at a time (mode 0,
// no result word; an index at or above MAX_VERTICES is dropped). A query word
// (mode 1) walks segments 0..n-2, n = min(vertex_count, MAX_VERTICES), and
// returns one word: the least L1 distance (Q.4, saturated at 131071) and an
// in-valley flag (distance < valley_radius). All multiplies and the divide run
// on one registered 18x18 multiplier and one bit-serial divider under a small
// sequencer; input stall is high for the whole query. A segment whose
// projection clamps to an end (or that is degenerate) skips the divide step;
// otherwise t is computed by the divider. With n below 2 a query returns
// 131071. Vertices must be loaded before a query reads them. Configuration is
// to be written only while idle by the user; the block does not enforce this.
module polyline_min_distance import pmd_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [DIST_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = ($clog2(MAX_VERTICES + 1) > CNT_BITS) ? $clog2(MAX_VERTICES + 1)
                                                            : CNT_BITS;
  localparam int IW = ((AW + 1) > IDX_BITS) ? (AW + 1) : IDX_BITS;
  localparam logic [NW-1:0] MAXV = NW'(MAX_VERTICES);
  localparam logic [IW-1:0] MAXI = IW'(MAX_VERTICES);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LDV, S_LDW, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_CHK, S_DIV, S_E1, S_E2, S_E3, S_CMP, S_OUT
  } state_t;

  state_t state;

  // config
  logic [CNT_BITS-1:0]  vertex_count;
  logic [DIST_BITS-1:0] valley_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RST;
      valley_radius <= VALLEY_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vertex_count  <= cfg_data[CNT_BITS-1:0];
        CFG_VALLEY_RADIUS: valley_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // vertex store, one write and one registered read per cycle
  logic [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic [COORD_BITS-1:0] rd_x, rd_y;
  logic [AW-1:0]         rd_addr;
  logic [IW-1:0]         idx_ext;
  logic                  accept, load_we;

  assign accept  = in_valid && !in_stall;
  assign idx_ext = IW'(in_data.vertex_index);
  assign load_we = accept && (in_data.mode == MODE_LOAD) && (idx_ext < MAXI);

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_x[idx_ext[AW-1:0]] <= in_data.coord_x;
      mem_y[idx_ext[AW-1:0]] <= in_data.coord_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // datapath registers
  logic signed [COORD_BITS-1:0] px, py, vx, vy, wx, wy;
  logic signed [DIFF_BITS-1:0]  ax, ay, dx, dy;
  logic signed [PROD_BITS-1:0]  acc, num;
  logic [LEN_BITS-1:0]          len2;
  logic [T_BITS-1:0]            t;
  logic [PROD_BITS-1:0]         ex;
  logic [21:0]                  seg_dist, best;
  logic [NW-1:0]                seg, nv;

  // shared multiplier
  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod;

  pmd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  always_comb begin
    case (state)
      S_M2:    begin mul_a = {dy[DIFF_BITS-1], dy}; mul_b = {dy[DIFF_BITS-1], dy}; end
      S_M3:    begin mul_a = {ax[DIFF_BITS-1], ax}; mul_b = {dx[DIFF_BITS-1], dx}; end
      S_M4:    begin mul_a = {ay[DIFF_BITS-1], ay}; mul_b = {dy[DIFF_BITS-1], dy}; end
      S_E1:    begin mul_a = {1'b0, t};             mul_b = {dx[DIFF_BITS-1], dx}; end
      S_E2:    begin mul_a = {1'b0, t};             mul_b = {dy[DIFF_BITS-1], dy}; end
      default: begin mul_a = {dx[DIFF_BITS-1], dx}; mul_b = {dx[DIFF_BITS-1], dx}; end
    endcase
  end

  // divider for t
  logic              div_start, div_done;
  logic [T_BITS-1:0] div_q;

  pmd_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(num[LEN_BITS-1:0]), .divisor(len2),
    .done(div_done), .quotient(div_q)
  );

  // combinational helpers
  logic signed [DIFF_BITS-1:0] dvx, dvy, dwx, dwy;
  logic [DIFF_BITS:0]          l1_v, l1_w;
  logic                        to_v, to_w;
  logic signed [PROD_BITS:0]   e_diff;
  logic [PROD_BITS-1:0]        e_abs;
  logic [PROD_BITS:0]          e_sum;
  logic signed [DIFF_BITS-1:0] e_ax;
  logic [NW-1:0]               cnt_ext, nv_c, rd_seg;
  logic [21:0]                 best_sat;

  always_comb begin
    dvx  = {px[COORD_BITS-1], px} - {vx[COORD_BITS-1], vx};
    dvy  = {py[COORD_BITS-1], py} - {vy[COORD_BITS-1], vy};
    dwx  = {px[COORD_BITS-1], px} - {wx[COORD_BITS-1], wx};
    dwy  = {py[COORD_BITS-1], py} - {wy[COORD_BITS-1], wy};
    l1_v = {1'b0, (dvx[DIFF_BITS-1] ? -dvx : dvx)} + {1'b0, (dvy[DIFF_BITS-1] ? -dvy : dvy)};
    l1_w = {1'b0, (dwx[DIFF_BITS-1] ? -dwx : dwx)} + {1'b0, (dwy[DIFF_BITS-1] ? -dwy : dwy)};
    to_v = (len2 == '0) || num[PROD_BITS-1];
    to_w = num > $signed({1'b0, len2});
    // axis error: a*2^16 - t*d, exact
    e_ax   = (state == S_E2) ? ax : ay;
    e_diff = $signed({{4{e_ax[DIFF_BITS-1]}}, e_ax, 16'b0}) - $signed({prod[PROD_BITS-1], prod});
    e_abs  = e_diff[PROD_BITS] ? PROD_BITS'(-e_diff) : e_diff[PROD_BITS-1:0];
    e_sum  = {1'b0, ex} + {1'b0, e_abs} + (PROD_BITS+1)'(32768);
    cnt_ext = NW'(vertex_count);
    nv_c    = (cnt_ext > MAXV) ? MAXV : cnt_ext;
    case (state)
      S_START: rd_seg = '0;
      S_CMP:   rd_seg = seg + NW'(2);
      default: rd_seg = seg + NW'(1);
    endcase
    rd_addr   = rd_seg[AW-1:0];
    div_start = (state == S_CHK) && !to_v && !to_w;
    best_sat  = (best > 22'(DIST_MAX)) ? 22'(DIST_MAX) : best;
  end

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && in_data.mode == MODE_QUERY) begin
            px   <= in_data.coord_x;
            py   <= in_data.coord_y;
            best <= START_DIST;
            seg  <= '0;
            nv   <= nv_c;
            state <= (nv_c >= NW'(2)) ? S_START : S_OUT;
          end
        end
        S_START: state <= S_LDV;
        S_LDV: begin
          vx    <= rd_x;
          vy    <= rd_y;
          state <= S_LDW;
        end
        S_LDW: begin
          wx <= rd_x;
          wy <= rd_y;
          dx <= {rd_x[COORD_BITS-1], rd_x} - {vx[COORD_BITS-1], vx};
          dy <= {rd_y[COORD_BITS-1], rd_y} - {vy[COORD_BITS-1], vy};
          ax <= dvx;
          ay <= dvy;
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          acc   <= prod;
          state <= S_M3;
        end
        S_M3: begin
          len2  <= LEN_BITS'(acc + prod);
          state <= S_M4;
        end
        S_M4: begin
          acc   <= prod;
          state <= S_M5;
        end
        S_M5: begin
          num   <= acc + prod;
          state <= S_CHK;
        end
        S_CHK: begin
          if (to_v) begin
            seg_dist <= 22'(l1_v);
            state    <= S_CMP;
          end else if (to_w) begin
            seg_dist <= 22'(l1_w);
            state    <= S_CMP;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t     <= div_q;
            state <= S_E1;
          end
        end
        S_E1: state <= S_E2;
        S_E2: begin
          ex    <= e_abs;
          state <= S_E3;
        end
        S_E3: begin
          seg_dist <= {1'b0, e_sum[PROD_BITS:16]};
          state    <= S_CMP;
        end
        S_CMP: begin
          if (seg_dist < best) best <= seg_dist;
          if (seg + NW'(2) < nv) begin
            seg   <= seg + NW'(1);
            vx    <= wx;
            vy    <= wy;
            state <= S_LDW;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.min_distance  <= best_sat[DIST_BITS-1:0];
            out_data.in_valley     <= best_sat[DIST_BITS-1:0] < valley_radius;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider done outside divide step");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result word without query end");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> best <= START_DIST) else $error("running minimum above start value");

endmodule

/* verif/tb_polyline_min_distance.sv */
module tb_polyline_min_distance import pmd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVERT      = 64;
  localparam int CYCLE_CAP  = 3000000;  // ~290 words at worst-case query length, many times over
  localparam int DRAIN_WAIT = 24;       // generous margin for a trailing load to settle

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [DIST_BITS-1:0] cfg_data;

  polyline_min_distance dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------
  // Shadow of the block: vertex store and both registers
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] vx_shadow [NVERT];
  logic signed [COORD_BITS-1:0] vy_shadow [NVERT];
  logic [CNT_BITS-1:0]  count_shadow;
  logic [DIST_BITS-1:0] radius_shadow;
  out_word_t            distance_queue [$];

  int  errors;
  int  cycles;
  bit  quiet;   // no idling on either side in the closing stretch

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_polyline_min_distance: FAIL");
      $finish;
    end
  end

  function automatic longint abs_l(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Q.4 L1 distance from p to segment v->w, exact until the final rounding
  function automatic longint seg_l1(longint ax, longint ay, longint bx, longint by,
                                    longint px, longint py);
    longint dx, dy, len2, num, t, ex, ey;
    dx = bx - ax;
    dy = by - ay;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return abs_l(px - ax) + abs_l(py - ay);
    num = (px - ax) * dx + (py - ay) * dy;
    if (num < 0) return abs_l(px - ax) + abs_l(py - ay);
    if (num > len2) return abs_l(px - bx) + abs_l(py - by);
    t  = (num * 65536) / len2;
    ex = abs_l((px - ax) * 65536 - t * dx);
    ey = abs_l((py - ay) * 65536 - t * dy);
    return (ex + ey + 32768) >>> 16;
  endfunction

  function automatic out_word_t polyline_dist(in_word_t w);
    longint    best, d;
    int        n;
    out_word_t r;
    best = 64'd1599984;   // 99999.0 in Q.4
    n = (count_shadow > NVERT) ? NVERT : count_shadow;
    for (int i = 0; i + 1 < n; i++) begin
      d = seg_l1(vx_shadow[i], vy_shadow[i], vx_shadow[i+1], vy_shadow[i+1],
                 w.coord_x, w.coord_y);
      if (d < best) best = d;
    end
    if (best > 131071) best = 131071;
    r.min_distance = best[DIST_BITS-1:0];
    r.in_valley    = (r.min_distance < radius_shadow);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted word
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (distance_queue.size() == 0) begin
        $display("%0t: unexpected word dist=%0d valley=%0b", $time,
                 out_data.min_distance, out_data.in_valley);
        errors++;
      end else begin
        if (out_data.min_distance !== distance_queue[0].min_distance) begin
          $display("%0t: min_distance expected %0d actual %0d", $time,
                   distance_queue[0].min_distance, out_data.min_distance);
          errors++;
        end
        if (out_data.in_valley !== distance_queue[0].in_valley) begin
          $display("%0t: in_valley expected %0b actual %0b", $time,
                   distance_queue[0].in_valley, out_data.in_valley);
          errors++;
        end
        void'(distance_queue.pop_front());
      end
    end
  end

  // Receiver stalls in random bursts, with calm stretches in between
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Present one word; on acceptance update the shadow or queue the expectation.
  // A typed expectation replaces the predicted one where given.
  task automatic push_word(in_word_t w, bit typed, out_word_t typed_res);
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (w.mode == MODE_LOAD) begin
      vx_shadow[w.vertex_index] = w.coord_x;
      vy_shadow[w.vertex_index] = w.coord_y;
    end else begin
      distance_queue.push_back(typed ? typed_res : polyline_dist(w));
    end
  endtask

  // Block idle: nothing owed, then let a trailing load settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [DIST_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_VERTEX_COUNT) count_shadow  = val[CNT_BITS-1:0];
    else                         radius_shadow = val;
  endtask

  function automatic in_word_t make_word(logic m, int idx, int x, int y);
    in_word_t w;
    w.mode = m;
    w.vertex_index = idx[IDX_BITS-1:0];
    w.coord_x = x[COORD_BITS-1:0];
    w.coord_y = y[COORD_BITS-1:0];
    return w;
  endfunction

  // Coordinates: full range often, tight clusters so projections land inside
  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0:       return $signed($urandom_range(0, 65535)) - 32768;
      1:       return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return $signed($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed table. Register rows are applied only once the block is idle.
  // ---------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_WORD, ROW_REG} row_kind_t;
  typedef struct {
    row_kind_t            kind;
    logic                 reg_idx;
    logic [DIST_BITS-1:0] reg_val;
    in_word_t             w;
    bit                   typed;
    out_word_t            res;
  } row_t;

  row_t plan [$];

  function automatic void add_reg(logic idx, int val);
    row_t r;
    r.kind = ROW_REG; r.reg_idx = idx; r.reg_val = val[DIST_BITS-1:0];
    r.typed = 0; r.res = '0; r.w = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_word(logic m, int idx, int x, int y,
                                   bit typed = 0, int dist_val = 0, bit flag = 0);
    row_t r;
    r.kind = ROW_WORD; r.reg_idx = CFG_VERTEX_COUNT; r.reg_val = '0;
    r.w = make_word(m, idx, x, y);
    r.typed = typed;
    r.res.min_distance = dist_val[DIST_BITS-1:0];
    r.res.in_valley = flag;
    plan.push_back(r);
  endfunction

  initial begin
    in_word_t  w;
    int        n_items;
    int        since_cfg;
    int        choice;

    rst = 1'b1; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = CFG_VERTEX_COUNT; cfg_data = '0;
    errors = 0; cycles = 0; quiet = 0;
    count_shadow  = VERTEX_COUNT_RST;
    radius_shadow = VALLEY_RADIUS_RST;
    for (int i = 0; i < NVERT; i++) begin
      vx_shadow[i] = '0;
      vy_shadow[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one segment (0,0)->(10.0,0); reset radius 45.0 still in force
    add_reg(CFG_VERTEX_COUNT, 2);
    add_word(MODE_LOAD, 0, 0, 0);
    add_word(MODE_LOAD, 1, 160, 0);
    add_word(MODE_QUERY, 0, 80, 32, 1, 32, 1);                 // projects inside
    add_word(MODE_QUERY, 0, -32768, -32768, 1, 65536, 0);      // clamps to start
    add_word(MODE_QUERY, 63, 32767, 32767, 1, 65374, 0);       // clamps to end
    add_word(MODE_LOAD, 1, 0, 0);                              // zero-length segment
    add_word(MODE_QUERY, 0, 16, -16, 1, 32, 1);
    // radius at both ends
    add_reg(CFG_VALLEY_RADIUS, 0);
    add_word(MODE_QUERY, 0, 0, 0, 1, 0, 0);                    // 0 < 0 is false
    add_reg(CFG_VALLEY_RADIUS, 131071);
    add_word(MODE_QUERY, 42, -1, -1, 1, 2, 1);
    // extreme vertices, a diagonal across the whole plane
    add_word(MODE_LOAD, 0, -32768, -32768);
    add_word(MODE_LOAD, 1, 32767, 32767);
    add_word(MODE_QUERY, 0, 32767, -32768);
    add_word(MODE_QUERY, 0, -32768, 32767);
    add_word(MODE_QUERY, 0, 100, -7);
    add_word(MODE_LOAD, 2, 32767, -32768);
    add_reg(CFG_VERTEX_COUNT, 3);
    add_word(MODE_QUERY, 0, 20000, -20000);
    // too few vertices: start distance saturates
    add_reg(CFG_VERTEX_COUNT, 0);
    add_word(MODE_QUERY, 0, 5, 5, 1, 131071, 0);
    add_reg(CFG_VERTEX_COUNT, 1);
    add_reg(CFG_VALLEY_RADIUS, 720);
    add_word(MODE_QUERY, 0, -5, 9, 1, 131071, 0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        sender_gap();
        push_word(plan[i].w, plan[i].typed, plan[i].res);
      end
    end

    // fill every vertex so any count is legal from here on
    for (int i = 0; i < NVERT; i++) begin
      sender_gap();
      push_word(make_word(MODE_LOAD, i, rand_coord(), rand_coord()), 0, '0);
    end

    n_items = 208;
    since_cfg = 1000;
    while (n_items > 0) begin
      if (since_cfg > 40 && !quiet) begin
        // reconfigure between phases, extremes included
        drain();
        choice = $urandom_range(0, 5);
        case (choice)
          0: write_reg(CFG_VERTEX_COUNT, DIST_BITS'(64));
          1: write_reg(CFG_VERTEX_COUNT, DIST_BITS'(127));
          2: write_reg(CFG_VERTEX_COUNT, DIST_BITS'(2));
          default: write_reg(CFG_VERTEX_COUNT, DIST_BITS'($urandom_range(2, 24)));
        endcase
        case ($urandom_range(0, 3))
          0: write_reg(CFG_VALLEY_RADIUS, DIST_BITS'(131071));
          1: write_reg(CFG_VALLEY_RADIUS, DIST_BITS'($urandom_range(0, 131071)));
          default: write_reg(CFG_VALLEY_RADIUS, DIST_BITS'($urandom_range(0, 4000)));
        endcase
        since_cfg = 0;
      end
      if (n_items == 40) quiet = 1;
      // hold off until every owed word is back, then carry on
      if (n_items == 120) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (distance_queue.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 7)
        w = make_word(MODE_QUERY, $urandom_range(0, 63), rand_coord(), rand_coord());
      else
        w = make_word(MODE_LOAD, $urandom_range(0, 63), rand_coord(), rand_coord());
      sender_gap();
      push_word(w, 0, '0);
      n_items--;
      since_cfg++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("tb_polyline_min_distance: PASS");
    end else begin
      $display("tb_polyline_min_distance: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pmd_pkg.sv
design/pmd_mul.sv
design/pmd_div.sv
design/polyline_min_distance.sv
verif/tb_polyline_min_distance.sv
